@@ design/oui_filtered_sighting_table_defines.svh @@
// ----------------------------------------------------------------------------
// oui_filtered_sighting_table_defines.svh
// Assertion macros used by the sighting table RTL.
// ----------------------------------------------------------------------------
`ifndef OUI_FILTERED_SIGHTING_TABLE_DEFINES_SVH
`define OUI_FILTERED_SIGHTING_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst
`define OFST_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define OFST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ofst_pkg.sv @@
// ----------------------------------------------------------------------------
// ofst_pkg
// Field widths, result codes and the vendor prefix list of the sighting table.
// ----------------------------------------------------------------------------
package ofst_pkg;

  localparam int MAC_W     = 48;
  localparam int RSSI_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 6;
  localparam int ENTRIES_W = 7;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REJECT = 3'd0,
    ST_UPDATE = 3'd1,
    ST_ADD    = 3'd2,
    ST_FULL   = 3'd3,
    ST_CLEAR  = 3'd4
  } status_t;

  // Known Wi-Fi vendor prefixes (top 24 address bits)
  localparam int KNOWN_PREFIXES = 20;
  localparam logic [23:0] VENDOR_PREFIX [KNOWN_PREFIXES] = '{
    24'h588E81, 24'hCCCCCC, 24'hEC1BBD, 24'h9035EA, 24'h040D84,
    24'hF082C0, 24'h1C34F1, 24'h385B44, 24'h943469, 24'hB4E3F9,
    24'h70C94E, 24'h3C9180, 24'hD8F3BC, 24'h803049, 24'h145AFC,
    24'h744CA1, 24'h083A88, 24'h9C2F9D, 24'h940853, 24'hE4AAEA
  };

endpackage

@@ design/ofst_if.sv @@
// ----------------------------------------------------------------------------
// ofst_if
// Valid/ready channels for sighting items and result items.
// ----------------------------------------------------------------------------
interface ofst_in_if;
  import ofst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     func;
  logic [MAC_W-1:0]         mac;
  logic signed [RSSI_W-1:0] rssi;
  logic                     via_ble;
  logic                     name_hit;

  modport source (output valid, func, mac, rssi, via_ble, name_hit, input ready);
  modport sink   (input valid, func, mac, rssi, via_ble, name_hit, output ready);
endinterface

interface ofst_out_if;
  import ofst_pkg::*;

  logic                 valid;
  logic                 ready;
  status_t              status;
  logic [SLOT_W-1:0]    slot;
  logic [ENTRIES_W-1:0] entries;

  modport source (output valid, status, slot, entries, input ready);
  modport sink   (input valid, status, slot, entries, output ready);
endinterface

@@ design/oui_filtered_sighting_table.sv @@
// ----------------------------------------------------------------------------
// oui_filtered_sighting_table
// De-duplicating table of radio sightings with a vendor prefix filter.
// ----------------------------------------------------------------------------
// Each sighting item is filtered (name flag, or a Wi-Fi address whose top
// 24 bits hit the vendor list), then searched linearly against the stored
// addresses, one entry per cycle through the single read port of the entry
// memory. A hit rewrites that entry's strength; a miss appends while there
// is room. A clear item only zeroes the entry count, so no clearing pass is
// needed and the block is ready right after reset. The search stops on a hit;
// an empty table skips it, and a clear or a rejected sighting goes straight
// to the result. The block works on one item at a time; the result register
// lets the next item in while a result waits.
// ----------------------------------------------------------------------------
`include "oui_filtered_sighting_table_defines.svh"

module oui_filtered_sighting_table #(
  parameter int TABLE_DEPTH  = 64,
  parameter int PREFIX_COUNT = 20
) (
  input logic         clk,
  input logic         rst,
  ofst_in_if.sink     sighting,
  ofst_out_if.source  result
);
  import ofst_pkg::*;

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int WORD_W = MAC_W + RSSI_W + 1;

  typedef enum logic [1:0] {IDLE, SCAN, APPEND, DONE} state_t;

  state_t                state;
  logic [MAC_W-1:0]      mac_q;
  logic [RSSI_W-1:0]     rssi_q;
  logic                  ble_q;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      scan_idx;
  logic [CNT_W-1:0]      cmp_idx;
  logic                  cmp_vld;
  logic [WORD_W-1:0]     rd_data;
  logic [WORD_W-1:0]     mem [TABLE_DEPTH];
  status_t               res_status;
  logic [IDX_W-1:0]      res_slot;
  logic                  out_valid;
  status_t               out_status;
  logic [SLOT_W-1:0]     out_slot;
  logic [ENTRIES_W-1:0]  out_entries;

  logic                  prefix_hit;
  logic                  filtered;
  logic                  issue;
  logic                  hit;
  logic                  last;
  logic                  room;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;
  logic [IDX_W+SLOT_W-1:0]    slot_ext;
  logic [CNT_W+ENTRIES_W-1:0] entries_ext;

  // Vendor prefix filter on the incoming address
  ofst_prefix_match #(
    .PREFIX_COUNT (PREFIX_COUNT)
  ) u_prefix (
    .mac (sighting.mac),
    .hit (prefix_hit)
  );

  assign filtered = sighting.name_hit || (!sighting.via_ble && prefix_hit);

  // Search control
  assign issue = (state == SCAN) && (scan_idx < count);
  assign hit   = cmp_vld && (rd_data[MAC_W-1:0] == mac_q);
  assign last  = cmp_vld && (CNT_W'(cmp_idx + CNT_W'(1)) == count);
  assign room  = count < CNT_W'(TABLE_DEPTH);

  // Write back on a hit, append on a miss with room
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_idx[IDX_W-1:0];
    wr_data = {rd_data[WORD_W-1], rssi_q, mac_q};
    if ((state == SCAN) && hit) begin
      wr_en = 1'b1;
    end else if ((state == APPEND) && room) begin
      wr_en   = 1'b1;
      wr_addr = count[IDX_W-1:0];
      wr_data = {ble_q, rssi_q, mac_q};
    end
  end

  // Entry memory: {radio, strength, address}
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[scan_idx[IDX_W-1:0]];
    end
  end

  // Fit result fields to the port widths
  assign slot_ext    = {{SLOT_W{1'b0}}, res_slot};
  assign entries_ext = {{ENTRIES_W{1'b0}}, count};

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      cmp_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      cmp_vld <= issue;
      if (issue) begin
        cmp_idx  <= scan_idx;
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (result.ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (sighting.valid) begin
            mac_q    <= sighting.mac;
            rssi_q   <= sighting.rssi;
            ble_q    <= sighting.via_ble;
            scan_idx <= '0;
            res_slot <= '0;
            if (sighting.func) begin
              count      <= '0;
              res_status <= ST_CLEAR;
              state      <= DONE;
            end else if (!filtered) begin
              res_status <= ST_REJECT;
              state      <= DONE;
            end else if (count == '0) begin
              state <= APPEND;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (hit) begin
            res_status <= ST_UPDATE;
            res_slot   <= cmp_idx[IDX_W-1:0];
            state      <= DONE;
          end else if (last) begin
            state <= APPEND;
          end
        end
        APPEND: begin
          if (room) begin
            res_status <= ST_ADD;
            res_slot   <= count[IDX_W-1:0];
            count      <= count + CNT_W'(1);
          end else begin
            res_status <= ST_FULL;
            res_slot   <= '0;
          end
          state <= DONE;
        end
        DONE: begin
          if (!out_valid || result.ready) begin
            out_valid   <= 1'b1;
            out_status  <= res_status;
            out_slot    <= slot_ext[SLOT_W-1:0];
            out_entries <= entries_ext[ENTRIES_W-1:0];
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign sighting.ready = (state == IDLE);
  assign result.valid   = out_valid;
  assign result.status  = out_status;
  assign result.slot    = out_slot;
  assign result.entries = out_entries;

  // Checks
  `OFST_ASSERT_IMP(a_wr_state, wr_en, (state == SCAN) || (state == APPEND), "memory write outside search or append")
  `OFST_ASSERT_NEXT(a_accept_busy, sighting.valid && sighting.ready, state != IDLE, "accepted item left sequencer idle")
  `OFST_ASSERT_IMP(a_clear_empty, result.valid && (result.status == ST_CLEAR), result.entries == '0, "clear result reports entries")
  `OFST_ASSERT_IMP(a_cmp_bound, cmp_vld, cmp_idx < count, "compare beyond held entries")

endmodule

@@ design/ofst_prefix_match.sv @@
// ----------------------------------------------------------------------------
// ofst_prefix_match
// Compares the top 24 address bits against the vendor prefix list.
// ----------------------------------------------------------------------------
module ofst_prefix_match #(
  parameter int PREFIX_COUNT = 20
) (
  input  logic [ofst_pkg::MAC_W-1:0] mac,
  output logic                       hit
);
  import ofst_pkg::*;

  // Check every enabled prefix in parallel
  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < KNOWN_PREFIXES; i++) begin
      if ((i < PREFIX_COUNT) && (mac[MAC_W-1:MAC_W-24] == VENDOR_PREFIX[i])) begin
        hit = 1'b1;
      end
    end
  end

endmodule

@@ bench/sighting_table_checker.sv @@
// ----------------------------------------------------------------------------
// sighting_table_checker
// Watches both channels of the sighting table, predicts each result item from
// its own copy of the table and compares the result items field by field.
// ----------------------------------------------------------------------------
module sighting_table_checker #(
  parameter int TABLE_DEPTH  = 64,
  parameter int PREFIX_COUNT = 20
) (
  input  logic clk,
  input  logic rst,
  ofst_in_if   sighting,
  ofst_out_if  result,
  output int   mismatches,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import ofst_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [ENTRIES_W-1:0] entries;
  } table_result_t;

  // Wi-Fi vendor prefixes that let a sighting in without a name match
  localparam int OUI_LIST_LEN = 20;
  localparam logic [23:0] WATCHED_OUI [OUI_LIST_LEN] = '{
    24'h588E81, 24'hCCCCCC, 24'hEC1BBD, 24'h9035EA, 24'h040D84,
    24'hF082C0, 24'h1C34F1, 24'h385B44, 24'h943469, 24'hB4E3F9,
    24'h70C94E, 24'h3C9180, 24'hD8F3BC, 24'h803049, 24'h145AFC,
    24'h744CA1, 24'h083A88, 24'h9C2F9D, 24'h940853, 24'hE4AAEA
  };

  // Predicted table contents
  logic [MAC_W-1:0]  held_mac  [TABLE_DEPTH];
  logic [RSSI_W-1:0] held_rssi [TABLE_DEPTH];
  logic              held_ble  [TABLE_DEPTH];
  int unsigned       held_count;

  table_result_t pending_results [$];

  initial mismatches = 0;

  function automatic bit oui_watched(logic [MAC_W-1:0] mac);
    for (int i = 0; i < PREFIX_COUNT && i < OUI_LIST_LEN; i++)
      if (WATCHED_OUI[i] == mac[47:24]) return 1'b1;
    return 1'b0;
  endfunction

  // Apply one sighting item to the predicted table and return its result item
  function automatic table_result_t classify_sighting(
    logic func, logic [MAC_W-1:0] mac, logic [RSSI_W-1:0] rssi, logic ble, logic name
  );
    table_result_t r;
    r.status = ST_REJECT;
    r.slot   = '0;
    if (func) begin
      held_count = 0;
      r.status   = ST_CLEAR;
    end else if (name || (!ble && oui_watched(mac))) begin
      r.status = ST_FULL;
      // Known address: refresh the strength only
      for (int i = 0; i < held_count; i++) begin
        if (held_mac[i] == mac) begin
          held_rssi[i] = rssi;
          r.status     = ST_UPDATE;
          r.slot       = SLOT_W'(i);
          break;
        end
      end
      // New address: append while there is room
      if (r.status == ST_FULL && held_count < TABLE_DEPTH) begin
        held_mac[held_count]  = mac;
        held_rssi[held_count] = rssi;
        held_ble[held_count]  = ble;
        r.status              = ST_ADD;
        r.slot                = SLOT_W'(held_count);
        held_count++;
      end
    end
    r.entries = ENTRIES_W'(held_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("checker: %s mismatch, got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Predict on every accepted sighting, compare on every accepted result
  always @(posedge clk) begin
    table_result_t want;
    if (rst) begin
      held_count = 0;
      pending_results.delete();
    end else begin
      if (sighting.valid && sighting.ready)
        pending_results.push_back(classify_sighting(sighting.func, sighting.mac,
                                                    sighting.rssi, sighting.via_ble,
                                                    sighting.name_hit));
      if (result.valid && result.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", result.status, -1);
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
          if (result.slot !== want.slot)
            report_mismatch("slot", result.slot, want.slot);
          if (result.entries !== want.entries)
            report_mismatch("entries", result.entries, want.entries);
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives sighting items into the sighting table with random gaps and result
// stalls, one long receiver hold-off and a stretch without idling, and gives
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ofst_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int POOL_SIZE    = 128;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   sent_count;
  bit   steady;
  int   quiet_cycles;

  // Addresses reused by the random part so that the table fills and repeats hit
  logic [MAC_W-1:0] roster [POOL_SIZE];

  ofst_in_if  sig_ch ();
  ofst_out_if res_ch ();

  oui_filtered_sighting_table u_dut (
    .clk      (clk),
    .rst      (rst),
    .sighting (sig_ch),
    .result   (res_ch)
  );

  sighting_table_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .sighting    (sig_ch),
    .result      (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offer one item after a random gap, hold it until accepted
  task automatic offer_sighting(logic func, logic [MAC_W-1:0] mac,
                                logic signed [RSSI_W-1:0] rssi, logic ble, logic name);
    while (!steady && $urandom_range(99) < 37) begin
      sig_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sig_ch.valid    <= 1'b1;
    sig_ch.func     <= func;
    sig_ch.mac      <= mac;
    sig_ch.rssi     <= rssi;
    sig_ch.via_ble  <= ble;
    sig_ch.name_hit <= name;
    do @(posedge clk); while (sig_ch.ready !== 1'b1);
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold-off while the sender keeps offering
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= steady || ($urandom_range(99) >= 37);
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (sig_ch.valid && sig_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int               pick;
    int               idx;
    logic [MAC_W-1:0] mac;
    logic             ble;
    logic             name;
    logic signed [RSSI_W-1:0] rssi;

    rst             = 1'b1;
    sig_ch.valid    = 1'b0;
    sig_ch.func     = 1'b0;
    sig_ch.mac      = '0;
    sig_ch.rssi     = '0;
    sig_ch.via_ble  = 1'b0;
    sig_ch.name_hit = 1'b0;
    sent_count      = 0;
    steady          = 1'b0;
    quiet_cycles    = 0;

    // First half of the roster carries vendor prefixes, the rest is arbitrary
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < POOL_SIZE / 2)
        roster[i] = {VENDOR_PREFIX[$urandom_range(KNOWN_PREFIXES - 1)], 24'($urandom())};
      else
        roster[i] = {16'($urandom()), $urandom()};
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: clear on empty, prefix on each radio, name flag, repeats, extremes
    offer_sighting(1'b1, 48'h0, RSSI_W'(0), 1'b0, 1'b0);
    offer_sighting(1'b0, {24'h588E81, 24'h000001}, RSSI_W'(-128), 1'b0, 1'b0);
    offer_sighting(1'b0, {24'h588E81, 24'h000002}, RSSI_W'(-40), 1'b1, 1'b0);
    offer_sighting(1'b0, 48'hFFFF_FFFF_FFFF, RSSI_W'(0), 1'b1, 1'b1);
    offer_sighting(1'b0, 48'h0, RSSI_W'(-70), 1'b0, 1'b0);
    offer_sighting(1'b0, 48'h0, RSSI_W'(-70), 1'b0, 1'b1);
    offer_sighting(1'b0, {24'h588E81, 24'h000001}, RSSI_W'(-1), 1'b1, 1'b1);
    offer_sighting(1'b0, {24'hE4AAEA, 24'hFFFFFF}, RSSI_W'(-128), 1'b0, 1'b0);
    offer_sighting(1'b0, 48'hFFFF_FFFF_FFFF, RSSI_W'(-5), 1'b0, 1'b0);
    offer_sighting(1'b0, {24'hCCCCCC, 24'hABCDEF}, RSSI_W'(-90), 1'b0, 1'b1);
    offer_sighting(1'b0, 48'hFFFF_FFFF_FFFF, RSSI_W'(-12), 1'b0, 1'b1);
    offer_sighting(1'b1, 48'h1234_5678_9ABC, RSSI_W'(-3), 1'b1, 1'b1);
    offer_sighting(1'b0, 48'hFFFF_FFFF_FFFF, RSSI_W'(-60), 1'b0, 1'b1);
    offer_sighting(1'b0, {24'h588E81, 24'h000001}, RSSI_W'(-128), 1'b0, 1'b0);
    offer_sighting(1'b0, {24'hE4AAEA, 24'hFFFFFF}, RSSI_W'(0), 1'b0, 1'b0);
    offer_sighting(1'b0, {24'hE4AAEB, 24'h000000}, RSSI_W'(-50), 1'b0, 1'b0);
    offer_sighting(1'b0, {24'h588E81, 24'h000001}, RSSI_W'(-77), 1'b1, 1'b0);

    // Random: mostly accepted roster addresses, some broken ones, some noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 500 && n < 650);
      pick   = $urandom_range(999);
      idx    = $urandom_range(POOL_SIZE - 1);
      rssi   = RSSI_W'(-int'($urandom_range(128)));
      if (pick < 5) begin
        offer_sighting(1'b1, {16'($urandom()), $urandom()}, rssi,
                       1'($urandom()), 1'($urandom()));
      end else if (pick < 750) begin
        if (idx < POOL_SIZE / 2) begin
          ble  = 1'b0;
          name = 1'($urandom());
        end else begin
          ble  = 1'($urandom());
          name = 1'b1;
        end
        offer_sighting(1'b0, roster[idx], rssi, ble, name);
      end else if (pick < 870) begin
        // Prefix seen over Bluetooth, or an unlisted Wi-Fi address, no name match
        ble = (idx < POOL_SIZE / 2);
        offer_sighting(1'b0, roster[idx], rssi, ble, 1'b0);
      end else begin
        mac = {16'($urandom()), $urandom()};
        offer_sighting(1'b0, mac, rssi, 1'($urandom()), 1'($urandom()));
      end
    end
    steady = 1'b0;
    sig_ch.valid <= 1'b0;

    // Drain the remaining results, then watch for stray ones
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
